### sv/mqv_pkg.sv
// ----------------------------------------------------------------------------
// mqv_pkg
// shared types and constants for the majority quorum vote tally
// ----------------------------------------------------------------------------
package mqv_pkg;

  localparam int ID_W             = 64;
  localparam int REQ_W            = 2;
  localparam int MEMBER_W         = 7;
  localparam int COUNT_W          = 8;
  localparam int RESULT_W         = 12;
  localparam int RESULT_BYTES_W   = 16;
  localparam int MAX_NODES_DEFAULT = 8;
  localparam int MAX_NODES_LIMIT  = 64;

  // result bit positions inside m_tdata
  localparam int RES_ERR_BIT      = 0;
  localparam int RES_MEMBER_BIT   = 1;
  localparam int RES_COUNT_LO     = 2;
  localparam int RES_ACCEPTED_BIT = 9;
  localparam int RES_REJECTED_BIT = 10;
  localparam int RES_COMPLETE_BIT = 11;

  typedef enum logic [REQ_W-1:0] {
    REQ_ADD    = 2'd0,
    REQ_ACCEPT = 2'd1,
    REQ_REJECT = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_type_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

endpackage

### sv/majority_quorum_vote_tally_top.sv
// ----------------------------------------------------------------------------
// majority_quorum_vote_tally_top
// member table in a synchronous ram plus accept / reject vote counters
// ----------------------------------------------------------------------------
//
// channel | dir | payload
// --------+-----+----------------------------------------------------------
// s_*     | in  | tuser: req_type[1:0]; tdata: node_id[63:0]
// m_*     | out | tdata: op_error, was_member, member_count[6:0],
//         |     |        vote_accepted, vote_rejected, vote_complete, 4'b0
//
// steps: an item is accepted, then one ram read per stored member, then one
//   step for the last read to return, then the update; the serial walk over
//   the member ram sets the time an item takes, so it grows with the member count
// reset: rst clears the member count, both vote counters and the control;
//   the member ram needs no clearing, only entries below the count are read
// stalls: the result sits in an output register; a new item is taken while
//   it waits, only the update step holds until that register is free
//
module majority_quorum_vote_tally_top #(
  parameter int MAX_NODES = mqv_pkg::MAX_NODES_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [mqv_pkg::ID_W-1:0]          s_tdata,  // node_id[63:0]
  input  logic [mqv_pkg::REQ_W-1:0]         s_tuser,  // req_type[1:0]
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // op_error[0], was_member[1], member_count[8:2], vote_accepted[9],
  // vote_rejected[10], vote_complete[11], zero[15:12]
  output logic [mqv_pkg::RESULT_BYTES_W-1:0] m_tdata
);
  import mqv_pkg::*;

  // ram address width, at least one bit
  localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam logic [MEMBER_W-1:0] NODES_CAP = MEMBER_W'(MAX_NODES);

  // member id ram, one read and one write port
  logic [ID_W-1:0] member_ram [MAX_NODES];
  logic [AW-1:0]   rd_addr;
  logic            rd_en;
  logic [ID_W-1:0] rd_data;
  logic            wr_en;

  // control and tally state
  state_t                state, state_next;
  logic [MEMBER_W-1:0]   member_total;
  logic [COUNT_W-1:0]    accept_count;
  logic [COUNT_W-1:0]    reject_count;
  logic [MEMBER_W-1:0]   scan_idx;
  logic                  rd_pend;
  logic                  found;
  req_type_t             req;
  logic [ID_W-1:0]       id;

  logic found_now;
  logic out_free;
  logic table_full;
  logic [MEMBER_W-1:0]   member_total_next;
  logic [COUNT_W-1:0]    accept_next;
  logic [COUNT_W-1:0]    reject_next;
  logic                  err_next;
  logic [COUNT_W-1:0]    accept_thresh;
  logic [COUNT_W-1:0]    reject_thresh;
  logic [COUNT_W:0]      vote_sum;
  logic [RESULT_W-1:0]   result;

  assign s_tready   = (state == ST_IDLE);
  assign out_free   = !m_tvalid || m_tready;
  assign table_full = (member_total >= NODES_CAP);

  // compare the word that came back from last cycle's read
  assign found_now = found || (rd_pend && (rd_data == id));

  // read one stored member per cycle during the walk
  assign rd_en   = (state == ST_SCAN) && (scan_idx != member_total);
  assign rd_addr = scan_idx[AW-1:0];

  // new member goes to the first free slot
  assign wr_en = (state == ST_FINISH) && out_free && (req == REQ_ADD) &&
                 !table_full && !found;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= member_ram[rd_addr];
    end
    if (wr_en) begin
      member_ram[member_total[AW-1:0]] <= id;
    end
  end

  // next tally values, applied at the update step
  always_comb begin
    member_total_next = member_total;
    accept_next       = accept_count;
    reject_next       = reject_count;
    err_next          = 1'b0;
    case (req)
      REQ_ADD: begin
        if (table_full) begin
          err_next = 1'b1;
        end else if (!found) begin
          member_total_next = member_total + MEMBER_W'(1);
        end
      end
      REQ_ACCEPT: begin
        if (found && (accept_count != '1)) begin
          accept_next = accept_count + COUNT_W'(1);
        end
      end
      REQ_REJECT: begin
        if (found && (reject_count != '1)) begin
          reject_next = reject_count + COUNT_W'(1);
        end
      end
      REQ_CLEAR: begin
        accept_next = '0;
        reject_next = '0;
      end
      default: begin
        accept_next = accept_count;
      end
    endcase
  end

  // quorum thresholds: ceil((n+1)/2) for accept, ceil(n/2) for reject
  assign accept_thresh = (COUNT_W'(member_total_next) + COUNT_W'(2)) >> 1;
  assign reject_thresh = (COUNT_W'(member_total_next) + COUNT_W'(1)) >> 1;
  assign vote_sum      = {1'b0, accept_next} + {1'b0, reject_next};

  always_comb begin
    result = '0;
    result[RES_ERR_BIT]                           = err_next;
    result[RES_MEMBER_BIT]                        = found;
    result[RES_COUNT_LO +: MEMBER_W]              = member_total_next;
    result[RES_ACCEPTED_BIT] = (accept_next >= accept_thresh);
    result[RES_REJECTED_BIT] = (reject_next >= reject_thresh);
    result[RES_COMPLETE_BIT] = (vote_sum == (COUNT_W+1)'(member_total_next));
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_idx == member_total) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // item latch and the walk over the table
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx <= '0;
      rd_pend  <= 1'b0;
      found    <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          scan_idx <= '0;
          rd_pend  <= 1'b0;
          found    <= 1'b0;
        end
        ST_SCAN: begin
          found   <= found_now;
          rd_pend <= rd_en;
          if (rd_en) begin
            scan_idx <= scan_idx + MEMBER_W'(1);
          end
        end
        default: begin
          rd_pend <= 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      req <= req_type_t'(s_tuser);
      id  <= s_tdata;
    end
  end

  // tally registers
  always_ff @(posedge clk) begin
    if (rst) begin
      member_total <= '0;
      accept_count <= '0;
      reject_count <= '0;
    end else if ((state == ST_FINISH) && out_free) begin
      member_total <= member_total_next;
      accept_count <= accept_next;
      reject_count <= reject_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == ST_FINISH) && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_FINISH) && out_free) begin
      m_tdata <= {(RESULT_BYTES_W-RESULT_W)'(0), result};
    end
  end

endmodule

### sv/mqv_checker.sv
// ----------------------------------------------------------------------------
// mqv_checker
// port-level checks for the majority quorum vote tally
// ----------------------------------------------------------------------------
module mqv_checker #(
  parameter int MAX_NODES = mqv_pkg::MAX_NODES_DEFAULT
) (
  input logic                               clk,
  input logic                               rst,
  input logic                               s_tvalid,
  input logic                               s_tready,
  input logic                               m_tvalid,
  input logic                               m_tready,
  input logic [mqv_pkg::RESULT_BYTES_W-1:0] m_tdata
);
  import mqv_pkg::*;

  localparam logic [MEMBER_W-1:0] NODES_CAP = MEMBER_W'(MAX_NODES);

  logic [MEMBER_W-1:0] out_count;
  assign out_count = m_tdata[RES_COUNT_LO +: MEMBER_W];

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // an accepted item keeps the input closed while it is worked on
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input open right after accept");

  // stalled result is held
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

  // member count within table size
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_count <= NODES_CAP))
    else $error("member count beyond table size");

  // empty table means the reject threshold is zero
  a_empty_rejects: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (out_count == '0)) |-> m_tdata[RES_REJECTED_BIT])
    else $error("empty table without reject flag");

endmodule

bind majority_quorum_vote_tally_top mqv_checker #(.MAX_NODES(MAX_NODES)) u_mqv_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

### tb/sv/quorum_tally_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// quorum_tally_checker
// watches both streams, keeps its own member table and vote counters, and
// compares every result item field by field with the predicted tally
// ----------------------------------------------------------------------------
module quorum_tally_checker #(
  parameter int MAX_NODES = mqv_pkg::MAX_NODES_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  input  logic                               s_tready,
  input  logic [mqv_pkg::ID_W-1:0]           s_tdata,   // node_id[63:0]
  input  logic [mqv_pkg::REQ_W-1:0]          s_tuser,   // req_type[1:0]
  input  logic                               m_tvalid,
  input  logic                               m_tready,
  // op_error, was_member, member_count[6:0], accepted, rejected, complete
  input  logic [mqv_pkg::RESULT_BYTES_W-1:0] m_tdata,
  output int                                 fail_count,
  output int                                 outstanding
);
  import mqv_pkg::*;

  localparam int unsigned VOTE_CEIL = (1 << COUNT_W) - 1;

  typedef struct packed {
    logic                op_error;
    logic                was_member;
    logic [MEMBER_W-1:0] member_count;
    logic                accepted;
    logic                rejected;
    logic                complete;
  } tally_t;

  logic [ID_W-1:0] roster [MAX_NODES];
  int unsigned     roster_len;
  int unsigned     accepts;
  int unsigned     rejects;
  tally_t          expected_tallies [$];

  // applies one request to the table and counters, returns the tally after it
  function automatic tally_t tally_after(req_type_t req, logic [ID_W-1:0] id);
    tally_t      t;
    logic        hit;
    int unsigned n;
    hit = 1'b0;
    for (int i = 0; i < roster_len; i++) begin
      if (roster[i] == id) hit = 1'b1;
    end
    t.op_error = 1'b0;
    case (req)
      REQ_ADD: begin
        // fullness wins even over a duplicate id
        if (roster_len >= MAX_NODES) t.op_error = 1'b1;
        else if (!hit) begin
          roster[roster_len] = id;
          roster_len++;
        end
      end
      REQ_ACCEPT: if (hit && accepts < VOTE_CEIL) accepts++;
      REQ_REJECT: if (hit && rejects < VOTE_CEIL) rejects++;
      default: begin
        accepts = 0;
        rejects = 0;
      end
    endcase
    n = roster_len;
    t.was_member   = hit;
    t.member_count = n[MEMBER_W-1:0];
    t.accepted     = accepts >= ((n + 2) >> 1);
    t.rejected     = rejects >= ((n + 1) >> 1);
    t.complete     = (accepts + rejects) == n;
    return t;
  endfunction

  function automatic int field_bad(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin : watch
    tally_t want;
    tally_t got;
    int     bad;
    bad = 0;
    if (rst) begin
      roster_len = 0;
      accepts    = 0;
      rejects    = 0;
      expected_tallies.delete();
      fail_count <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.op_error     = m_tdata[RES_ERR_BIT];
        got.was_member   = m_tdata[RES_MEMBER_BIT];
        got.member_count = m_tdata[RES_COUNT_LO +: MEMBER_W];
        got.accepted     = m_tdata[RES_ACCEPTED_BIT];
        got.rejected     = m_tdata[RES_REJECTED_BIT];
        got.complete     = m_tdata[RES_COMPLETE_BIT];
        if (expected_tallies.size() == 0) begin
          $error("result item with no request outstanding: %h", m_tdata);
          bad++;
        end else begin
          want = expected_tallies.pop_front();
          bad += field_bad("op_error", int'(want.op_error), int'(got.op_error));
          bad += field_bad("was_member", int'(want.was_member),
                           int'(got.was_member));
          bad += field_bad("member_count", int'(want.member_count),
                           int'(got.member_count));
          bad += field_bad("vote_accepted", int'(want.accepted), int'(got.accepted));
          bad += field_bad("vote_rejected", int'(want.rejected), int'(got.rejected));
          bad += field_bad("vote_complete", int'(want.complete), int'(got.complete));
          bad += field_bad("pad", 0, int'(m_tdata[RESULT_BYTES_W-1:RESULT_W]));
        end
      end
      if (s_tvalid && s_tready)
        expected_tallies.push_back(tally_after(req_type_t'(s_tuser), s_tdata));
      fail_count <= fail_count + bad;
    end
    outstanding <= expected_tallies.size();
  end

endmodule

### tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// stimulus and verdict for the majority quorum vote tally: directed edge
// cases, then random membership / vote traffic with bursty input and a
// stalling receiver, then a long vote run that drives both counters into
// saturation; all checking sits in quorum_tally_checker
// ----------------------------------------------------------------------------
module tb;
  import mqv_pkg::*;

  localparam int NODES      = MAX_NODES_DEFAULT;
  localparam int QUIET_MAX  = 4000;       // cycles with no item moving on either side
  localparam int TAIL_WAIT  = NODES + 10; // longer than one item through the block
  localparam int HOLD_LEN   = 300;        // long receiver hold-off
  localparam int RANDOM_N   = 160;
  localparam int FLOOD_N    = 520;        // > 2 * 255 votes, saturates both counters

  logic                      clk;
  logic                      rst;
  logic                      s_tvalid;
  logic                      s_tready;
  logic [ID_W-1:0]           s_tdata;   // node_id[63:0]
  logic [REQ_W-1:0]          s_tuser;   // req_type[1:0]
  logic                      m_tvalid;
  logic                      m_tready;
  // op_error[0], was_member[1], member_count[8:2], vote_accepted[9],
  // vote_rejected[10], vote_complete[11], zero[15:12]
  logic [RESULT_BYTES_W-1:0] m_tdata;

  int fail_count;
  int outstanding;

  // ids the stimulus believes are in the table, used to aim votes
  logic [ID_W-1:0] known_ids [$];
  int              burst_left;
  int              quiet;

  majority_quorum_vote_tally_top #(
    .MAX_NODES(NODES)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  quorum_tally_checker #(
    .MAX_NODES(NODES)
  ) checker_i (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic logic is_known(logic [ID_W-1:0] id);
    foreach (known_ids[i]) begin
      if (known_ids[i] == id) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [ID_W-1:0] rand_id();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [ID_W-1:0] pick_member();
    return known_ids[$urandom_range(0, known_ids.size() - 1)];
  endfunction

  // a member id with one bit flipped: exercises the full 64-bit compare
  function automatic logic [ID_W-1:0] near_miss();
    return pick_member() ^ (64'd1 << $urandom_range(0, ID_W - 1));
  endfunction

  // mostly members, some near misses and some unrelated ids
  function automatic logic [ID_W-1:0] pick_voter();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 8) return pick_member();
    if (sel == 8) return near_miss();
    return rand_id();
  endfunction

  // presents one item, holds it until taken, then applies the burst / gap
  // pacing; valid only drops when a gap follows
  task automatic offer(req_type_t req, logic [ID_W-1:0] id);
    int gap;
    s_tvalid <= 1'b1;
    s_tuser  <= req;
    s_tdata  <= id;
    do @(posedge clk); while (!s_tready);
    if (req == REQ_ADD && !is_known(id) && known_ids.size() < NODES)
      known_ids.push_back(id);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      // a quarter of the bursts run straight into the next one
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
  endtask

  // sender pause: nothing offered until every result has come back
  task automatic settle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic random_item(int clear_pct);
    int r;
    int how;
    r = $urandom_range(0, 99);
    if (r < 12) begin
      // adds: fresh ids, duplicates and near misses of members
      how = $urandom_range(0, 3);
      if (how < 2) offer(REQ_ADD, rand_id());
      else if (how == 2) offer(REQ_ADD, pick_member());
      else offer(REQ_ADD, near_miss());
    end else if (r < 12 + clear_pct) begin
      offer(REQ_CLEAR, pick_voter());
    end else if ($urandom_range(0, 1) == 0) begin
      offer(REQ_ACCEPT, pick_voter());
    end else begin
      offer(REQ_REJECT, pick_voter());
    end
  endtask

  // ---------------------------------------------------------------------------
  // receiver: stall pattern changes at random, plus two long
  // hold-offs that back the block up into its input
  // ---------------------------------------------------------------------------
  initial begin : receiver
    int mode;
    int mode_left;
    int taken;
    int holds_done;
    int phase;
    mode_left  = 0;
    taken      = 0;
    holds_done = 0;
    phase      = 0;
    m_tready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      @(posedge clk);
      phase++;
      if (m_tvalid && m_tready) taken++;
      if (holds_done < 2 && taken >= (holds_done == 0 ? 60 : 500)) begin
        // long hold-off while the sender keeps offering
        holds_done++;
        m_tready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 120);
        end
        mode_left--;
        case (mode)
          0:       m_tready <= 1'b1;                          // no stalls
          1:       m_tready <= 1'($urandom_range(0, 1));      // coin flip
          2:       m_tready <= ($urandom_range(0, 3) == 0);   // mostly stalled
          default: m_tready <= phase[2];                      // regular on / off pattern
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: ends the run when nothing moves for too long
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_MAX) begin
      $display("[majority_quorum_vote_tally_top] ERROR");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int clear_pct;
    clear_pct  = 10;
    burst_left = 0;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= REQ_ADD;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty table: reject threshold is zero, complete while counters are zero
    offer(REQ_CLEAR, 64'd0);
    offer(REQ_ACCEPT, '1);                      // vote from a non-member, ignored
    offer(REQ_REJECT, 64'h5555_5555_5555_5555);
    // extremes of node_id as members, and a duplicate add
    offer(REQ_ADD, 64'd0);
    offer(REQ_ADD, '1);
    offer(REQ_ADD, '1);
    offer(REQ_ACCEPT, 64'd0);
    offer(REQ_REJECT, '1);
    // one bit away from a member is not a member
    offer(REQ_ACCEPT, 64'd1);
    offer(REQ_REJECT, 64'h7fff_ffff_ffff_ffff);
    // repeated votes from one member count again
    offer(REQ_ACCEPT, 64'd0);
    offer(REQ_ACCEPT, 64'd0);
    // clear keeps membership and still reports was_member
    offer(REQ_CLEAR, 64'd0);
    offer(REQ_ADD, 64'ha5a5_a5a5_a5a5_a5a5);
    offer(REQ_ADD, 64'h8000_0000_0000_0000);
    offer(REQ_REJECT, 64'h8000_0000_0000_0000);
    settle();

    // random traffic; the table fills up part way through, after which
    // adds (duplicates included) are refused as full
    for (int k = 0; k < RANDOM_N; k++) begin
      if (k % 50 == 0) begin
        case ($urandom_range(0, 3))
          0:       clear_pct = 2;
          1:       clear_pct = 5;
          2:       clear_pct = 12;
          default: clear_pct = 25;
        endcase
      end
      random_item(clear_pct);
    end
    settle();

    // long vote run from members only, no clears: both counters saturate
    offer(REQ_CLEAR, pick_member());
    for (int k = 0; k < FLOOD_N; k++)
      offer((k % 2 == 1) ? REQ_REJECT : REQ_ACCEPT, pick_member());
    offer(REQ_CLEAR, pick_voter());
    settle();

    // catch any stray result after the last expected one
    repeat (TAIL_WAIT) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("[majority_quorum_vote_tally_top] OK");
    end else begin
      $display("[majority_quorum_vote_tally_top] ERROR");
    end
    $finish;
  end

endmodule

### majority_quorum_vote_tally_top.f
sv/mqv_pkg.sv
sv/majority_quorum_vote_tally_top.sv
sv/mqv_checker.sv
tb/sv/quorum_tally_checker.sv
tb/sv/tb.sv
